// File: sv/mep_pkg.sv
// ============================================================================
// mep_pkg: shared types and constants of the midpoint ellipse pixel generator
// Holds the datapath operation codes, the status bundle, register indexes and
// the per-arc sign and direction tables.
// ============================================================================
package mep_pkg;

  // Default parameter values and fixed field widths.
  localparam int RADIUS_BITS_DEF = 10;
  localparam int COORD_BITS_DEF  = 12;
  localparam int OUT_COORD_BITS  = 14;
  localparam int COLOR_BITS      = 24;
  localparam int ARC_BITS        = 3;
  localparam int CFG_IDX_BITS    = 3;
  localparam int CFG_DATA_BITS   = 24;

  // Index of the eighth and last arc of a pass.
  localparam logic [ARC_BITS-1:0] LAST_ARC = 3'd7;

  // Configuration register indexes.
  localparam logic [CFG_IDX_BITS-1:0] REG_CENTER_X    = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_CENTER_Y    = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_RADIUS_X    = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_RADIUS_Y    = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_PIXEL_COLOR = 3'd4;

  // Operation the controller asks of the datapath in a given cycle.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_TAKE,
    OP_SQ,
    OP_LIM_MUL,
    OP_LIM_SAVE,
    OP_K_SQ,
    OP_K_MUL,
    OP_K_TEST,
    OP_END_SAVE,
    OP_PASS_INIT,
    OP_ARC_MUL,
    OP_ARC_INIT,
    OP_STEP_OUT,
    OP_STEP_ADV
  } dp_op_e;

  // Status flags the datapath reports back to the controller.
  typedef struct packed {
    logic need_start;  // restart requested or no pass running
    logic end_sel;     // 0 while the slow end is searched, 1 for the fast end
    logic bit_last;    // the end search is testing its lowest bit
    logic arc_last;    // current pixel is the last one of its arc
    logic pass_last;   // current arc is the last arc of the pass
    logic out_free;    // output register can take a new beat
  } dp_status_t;

  // Fast arcs step y and move x; slow arcs step x and move y.
  function automatic logic arc_fast(input logic [ARC_BITS-1:0] arc);
    return arc[1];
  endfunction

  // Arcs whose x offset is subtracted from the center.
  function automatic logic arc_x_neg(input logic [ARC_BITS-1:0] arc);
    logic neg;
    case (arc)
      3'd0, 3'd5, 3'd6, 3'd7: neg = 1'b1;
      default:                neg = 1'b0;
    endcase
    return neg;
  endfunction

  // Arcs whose y offset is subtracted from the center.
  function automatic logic arc_y_neg(input logic [ARC_BITS-1:0] arc);
    logic neg;
    case (arc)
      3'd3, 3'd4, 3'd5, 3'd6: neg = 1'b1;
      default:                neg = 1'b0;
    endcase
    return neg;
  endfunction

endpackage

// File: sv/mep_if.sv
// ============================================================================
// mep_if: handshake channels of the midpoint ellipse pixel generator
// Input tick channel, pixel result channel and configuration write channel,
// each with valid, ready and its payload.
// ============================================================================

// Input tick channel.
interface mep_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

// Pixel result channel.
interface mep_out_if;
  logic                                       valid;
  logic                                       ready;
  logic signed [mep_pkg::OUT_COORD_BITS-1:0]  pixel_x;
  logic signed [mep_pkg::OUT_COORD_BITS-1:0]  pixel_y;
  logic        [mep_pkg::COLOR_BITS-1:0]      color_out;
  logic        [mep_pkg::ARC_BITS-1:0]        arc_number;
  logic                                       arc_done;
  logic                                       pass_done;

  modport source (output valid, output pixel_x, output pixel_y, output color_out,
                  output arc_number, output arc_done, output pass_done, input ready);
  modport sink   (input valid, input pixel_x, input pixel_y, input color_out,
                  input arc_number, input arc_done, input pass_done, output ready);
endinterface

// Configuration write channel.
interface mep_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [mep_pkg::CFG_IDX_BITS-1:0]    index;
  logic [mep_pkg::CFG_DATA_BITS-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: sv/mep_dp.sv
// ============================================================================
// mep_dp: datapath of the midpoint ellipse pixel generator
// Holds the arc walk state, the decision variable and its increments, the
// exact arc end search (one shared multiplier) and the output register.
// ============================================================================
module mep_dp #(
  parameter int RADIUS_BITS = mep_pkg::RADIUS_BITS_DEF,
  parameter int COORD_BITS  = mep_pkg::COORD_BITS_DEF
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  mep_pkg::dp_op_e                           op_i,
  output mep_pkg::dp_status_t                       status_o,
  input  logic                                      restart_i,
  input  logic [COORD_BITS-1:0]                     center_x_i,
  input  logic [COORD_BITS-1:0]                     center_y_i,
  input  logic [RADIUS_BITS-1:0]                    radius_x_i,
  input  logic [RADIUS_BITS-1:0]                    radius_y_i,
  input  logic [mep_pkg::COLOR_BITS-1:0]            pixel_color_i,
  output logic                                      out_valid_o,
  input  logic                                      out_ready_i,
  output logic signed [mep_pkg::OUT_COORD_BITS-1:0] pixel_x_o,
  output logic signed [mep_pkg::OUT_COORD_BITS-1:0] pixel_y_o,
  output logic [mep_pkg::COLOR_BITS-1:0]            color_out_o,
  output logic [mep_pkg::ARC_BITS-1:0]              arc_number_o,
  output logic                                      arc_done_o,
  output logic                                      pass_done_o
);

  localparam int SQ_BITS   = 2 * RADIUS_BITS;
  localparam int DEN_BITS  = 2 * RADIUS_BITS + 1;
  localparam int MUL_BITS  = 2 * RADIUS_BITS + 2;
  localparam int PROD_BITS = 2 * MUL_BITS;
  localparam int DEC_BITS  = 4 * RADIUS_BITS;
  localparam int WALK_BITS = RADIUS_BITS + 2;
  localparam int SUM_BITS  = mep_pkg::OUT_COORD_BITS + COORD_BITS + WALK_BITS;
  localparam int OUT_BITS  = mep_pkg::OUT_COORD_BITS;

  localparam logic [RADIUS_BITS-1:0]      BIT_MSB  = {1'b1, {(RADIUS_BITS - 1){1'b0}}};
  localparam logic [RADIUS_BITS-1:0]      STEP_ONE = {{(RADIUS_BITS - 1){1'b0}}, 1'b1};
  localparam logic [RADIUS_BITS:0]        ODD_ONE  = {{RADIUS_BITS{1'b0}}, 1'b1};
  localparam logic signed [WALK_BITS-1:0] WALK_ONE = {{(WALK_BITS - 1){1'b0}}, 1'b1};
  localparam logic [mep_pkg::ARC_BITS-1:0] ARC_ONE = {{(mep_pkg::ARC_BITS - 1){1'b0}}, 1'b1};

  // Stored state.
  logic                               restart_q;
  logic [SQ_BITS-1:0]                 a2_q, b2_q;
  logic [DEN_BITS-1:0]                den_q;
  logic [PROD_BITS-1:0]               lim_q, prod_q;
  logic [RADIUS_BITS-1:0]             k_q, bit_q;
  logic [RADIUS_BITS-1:0]             slow_end_q, fast_end_q;
  logic                               end_sel_q;
  logic                               pass_started_q;
  logic [mep_pkg::ARC_BITS-1:0]       arc_q;
  logic signed [WALK_BITS-1:0]        walk_x_q, walk_y_q;
  logic [RADIUS_BITS-1:0]             step_q;
  logic signed [DEC_BITS-1:0]         dec_q, inc_m_q, inc_n_q;
  logic                               out_valid_q;
  logic signed [OUT_BITS-1:0]         pixel_x_q, pixel_y_q;
  logic [mep_pkg::COLOR_BITS-1:0]     color_q;
  logic [mep_pkg::ARC_BITS-1:0]       arc_out_q;
  logic                               arc_done_q, pass_done_q;

  // Combinational signals.
  logic                               fast;
  logic [SQ_BITS-1:0]                 e2_sel;
  logic [RADIUS_BITS-1:0]             k_cand;
  logic [RADIUS_BITS:0]               k_odd;
  logic [MUL_BITS-1:0]                mul_a, mul_b;
  logic [PROD_BITS-1:0]               prod_d;
  logic signed [DEC_BITS-1:0]         a2_s, b2_s, prod_s;
  logic signed [DEC_BITS-1:0]         two_a2_s, two_b2_s, both_inc, axis_inc;
  logic signed [DEC_BITS-1:0]         major, minor;
  logic signed [DEC_BITS-1:0]         dec_init, inc_m_init, inc_n_init;
  logic signed [DEC_BITS-1:0]         inc_m_step, inc_n_step, dec_adv;
  logic                               dec_neg, move;
  logic signed [WALK_BITS-1:0]        wx_step, wy_step;
  logic [RADIUS_BITS-1:0]             end_cur;
  logic                               last;
  logic signed [SUM_BITS-1:0]         cx_ext, cy_ext, wx_ext, wy_ext, x_sum, y_sum;

  assign fast   = mep_pkg::arc_fast(arc_q);
  assign e2_sel = end_sel_q ? b2_q : a2_q;
  assign k_cand = k_q | bit_q;
  assign k_odd  = {k_cand, 1'b0} - ODD_ONE;

  // Shared multiplier operand selection.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (op_i)
      mep_pkg::OP_LIM_MUL: begin
        mul_a = MUL_BITS'({e2_sel, 1'b0});
        mul_b = MUL_BITS'({e2_sel, 1'b0});
      end
      mep_pkg::OP_K_SQ: begin
        mul_a = MUL_BITS'(k_odd);
        mul_b = MUL_BITS'(k_odd);
      end
      mep_pkg::OP_K_MUL: begin
        mul_a = prod_q[MUL_BITS-1:0];
        mul_b = MUL_BITS'(den_q);
      end
      mep_pkg::OP_PASS_INIT: begin
        mul_a = MUL_BITS'(a2_q);
        mul_b = MUL_BITS'(radius_y_i);
      end
      mep_pkg::OP_ARC_MUL: begin
        mul_a = fast ? MUL_BITS'(b2_q) : MUL_BITS'(a2_q);
        mul_b = fast ? MUL_BITS'(radius_x_i) : MUL_BITS'(radius_y_i);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_d = PROD_BITS'(mul_a) * PROD_BITS'(mul_b);

  // Signed views of the squared radii and the last product.
  assign a2_s     = DEC_BITS'(a2_q);
  assign b2_s     = DEC_BITS'(b2_q);
  assign prod_s   = prod_q[DEC_BITS-1:0];
  assign two_a2_s = a2_s <<< 1;
  assign two_b2_s = b2_s <<< 1;

  // Arc start values of the decision variable and its increments.
  assign major      = fast ? a2_s : b2_s;
  assign minor      = fast ? b2_s : a2_s;
  assign dec_init   = (minor >>> 2) + major - prod_s;
  assign inc_m_init = major + (major <<< 1);
  assign inc_n_init = inc_m_init + (minor <<< 1) - (prod_s <<< 1);

  // One pixel step: move on the slow axis when the decision says so.
  assign dec_neg    = dec_q[DEC_BITS-1];
  assign move       = fast ? !dec_neg : (!dec_neg && (dec_q != '0));
  assign axis_inc   = fast ? two_a2_s : two_b2_s;
  assign both_inc   = two_a2_s + two_b2_s;
  assign inc_m_step = inc_m_q + axis_inc;
  assign inc_n_step = inc_n_q + (move ? both_inc : axis_inc);
  assign wx_step    = (fast && move) ? walk_x_q - WALK_ONE : walk_x_q;
  assign wy_step    = (!fast && move) ? walk_y_q - WALK_ONE : walk_y_q;
  assign dec_adv    = dec_q + (dec_neg ? inc_m_q : inc_n_q);

  assign end_cur = fast ? fast_end_q : slow_end_q;
  assign last    = step_q >= end_cur;

  // Pixel coordinates, wrapped to the output width.
  assign cx_ext = SUM_BITS'(center_x_i);
  assign cy_ext = SUM_BITS'(center_y_i);
  assign wx_ext = SUM_BITS'(wx_step);
  assign wy_ext = SUM_BITS'(wy_step);
  assign x_sum  = mep_pkg::arc_x_neg(arc_q) ? cx_ext - wx_ext : cx_ext + wx_ext;
  assign y_sum  = mep_pkg::arc_y_neg(arc_q) ? cy_ext - wy_ext : cy_ext + wy_ext;

  // Control state: pass progress, end search select and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pass_started_q <= 1'b0;
      arc_q          <= '0;
      end_sel_q      <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      case (op_i)
        mep_pkg::OP_PASS_INIT: begin
          pass_started_q <= 1'b1;
          arc_q          <= '0;
        end
        mep_pkg::OP_END_SAVE: begin
          end_sel_q <= !end_sel_q;
        end
        mep_pkg::OP_STEP_ADV: begin
          if (last) begin
            if (arc_q == mep_pkg::LAST_ARC) begin
              pass_started_q <= 1'b0;
              arc_q          <= '0;
            end else begin
              arc_q <= arc_q + ARC_ONE;
            end
          end
        end
        default: begin
        end
      endcase
      if (op_i == mep_pkg::OP_STEP_OUT) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    case (op_i) inside
      mep_pkg::OP_TAKE: begin
        restart_q <= restart_i;
      end
      mep_pkg::OP_SQ: begin
        a2_q <= SQ_BITS'(radius_x_i) * SQ_BITS'(radius_x_i);
        b2_q <= SQ_BITS'(radius_y_i) * SQ_BITS'(radius_y_i);
      end
      mep_pkg::OP_LIM_MUL: begin
        prod_q <= prod_d;
        den_q  <= DEN_BITS'(a2_q) + DEN_BITS'(b2_q);
        k_q    <= '0;
        bit_q  <= BIT_MSB;
      end
      mep_pkg::OP_LIM_SAVE: begin
        lim_q <= prod_q;
      end
      mep_pkg::OP_K_SQ, mep_pkg::OP_K_MUL, mep_pkg::OP_PASS_INIT, mep_pkg::OP_ARC_MUL: begin
        prod_q <= prod_d;
      end
      mep_pkg::OP_K_TEST: begin
        // Keep the candidate bit while (2k-1)^2 * (a^2+b^2) stays within 4e^4.
        if (prod_q <= lim_q) begin
          k_q <= k_cand;
        end
        bit_q <= bit_q >> 1;
      end
      mep_pkg::OP_END_SAVE: begin
        if (end_sel_q) begin
          fast_end_q <= (den_q == '0) ? '0 : k_q;
        end else begin
          slow_end_q <= (den_q == '0) ? '0 : k_q;
        end
      end
      mep_pkg::OP_ARC_INIT: begin
        dec_q    <= dec_init;
        inc_m_q  <= inc_m_init;
        inc_n_q  <= inc_n_init;
        walk_x_q <= fast ? $signed({2'b00, radius_x_i}) : '0;
        walk_y_q <= fast ? '0 : $signed({2'b00, radius_y_i});
        step_q   <= '0;
      end
      mep_pkg::OP_STEP_OUT: begin
        walk_x_q    <= wx_step;
        walk_y_q    <= wy_step;
        inc_m_q     <= inc_m_step;
        inc_n_q     <= inc_n_step;
        pixel_x_q   <= x_sum[OUT_BITS-1:0];
        pixel_y_q   <= y_sum[OUT_BITS-1:0];
        color_q     <= pixel_color_i;
        arc_out_q   <= arc_q;
        arc_done_q  <= last;
        pass_done_q <= last && (arc_q == mep_pkg::LAST_ARC);
      end
      mep_pkg::OP_STEP_ADV: begin
        dec_q <= dec_adv;
        if (fast) begin
          walk_y_q <= walk_y_q + WALK_ONE;
        end else begin
          walk_x_q <= walk_x_q + WALK_ONE;
        end
        if (!last) begin
          step_q <= step_q + STEP_ONE;
        end
      end
      default: begin
      end
    endcase
  end

  // Status back to the controller.
  assign status_o.need_start = restart_q || !pass_started_q;
  assign status_o.end_sel    = end_sel_q;
  assign status_o.bit_last   = bit_q[0];
  assign status_o.arc_last   = last;
  assign status_o.pass_last  = (arc_q == mep_pkg::LAST_ARC);
  assign status_o.out_free   = !out_valid_q || out_ready_i;

  // Output channel.
  assign out_valid_o  = out_valid_q;
  assign pixel_x_o    = pixel_x_q;
  assign pixel_y_o    = pixel_y_q;
  assign color_out_o  = color_q;
  assign arc_number_o = arc_out_q;
  assign arc_done_o   = arc_done_q;
  assign pass_done_o  = pass_done_q;

endmodule

// File: sv/mep_ctrl.sv
// ============================================================================
// mep_ctrl: sequencer of the midpoint ellipse pixel generator
// Takes one tick at a time and steps the datapath through the squares, the
// exact arc end search on a pass start, the pixel step and the arc start.
// ============================================================================
module mep_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  mep_pkg::dp_status_t status_i,
  output mep_pkg::dp_op_e     op_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SQ,
    S_LIM_MUL,
    S_LIM_SAVE,
    S_K_SQ,
    S_K_MUL,
    S_K_TEST,
    S_END_SAVE,
    S_PASS_INIT,
    S_START_INIT,
    S_STEP_OUT,
    S_STEP_ADV,
    S_ARC_MUL,
    S_NEXT_INIT
  } state_e;

  state_e state_q, state_d;
  logic   in_ready_q;

  // Next state and the operation issued in the current state.
  always_comb begin
    state_d = state_q;
    op_o    = mep_pkg::OP_NONE;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_o    = mep_pkg::OP_TAKE;
          state_d = S_SQ;
        end
      end
      S_SQ: begin
        op_o    = mep_pkg::OP_SQ;
        state_d = status_i.need_start ? S_LIM_MUL : S_STEP_OUT;
      end
      S_LIM_MUL: begin
        op_o    = mep_pkg::OP_LIM_MUL;
        state_d = S_LIM_SAVE;
      end
      S_LIM_SAVE: begin
        op_o    = mep_pkg::OP_LIM_SAVE;
        state_d = S_K_SQ;
      end
      S_K_SQ: begin
        op_o    = mep_pkg::OP_K_SQ;
        state_d = S_K_MUL;
      end
      S_K_MUL: begin
        op_o    = mep_pkg::OP_K_MUL;
        state_d = S_K_TEST;
      end
      S_K_TEST: begin
        op_o    = mep_pkg::OP_K_TEST;
        state_d = status_i.bit_last ? S_END_SAVE : S_K_SQ;
      end
      S_END_SAVE: begin
        op_o    = mep_pkg::OP_END_SAVE;
        state_d = status_i.end_sel ? S_PASS_INIT : S_LIM_MUL;
      end
      S_PASS_INIT: begin
        op_o    = mep_pkg::OP_PASS_INIT;
        state_d = S_START_INIT;
      end
      S_START_INIT: begin
        op_o    = mep_pkg::OP_ARC_INIT;
        state_d = S_STEP_OUT;
      end
      S_STEP_OUT: begin
        // Hold until the output register can take the pixel.
        if (status_i.out_free) begin
          op_o    = mep_pkg::OP_STEP_OUT;
          state_d = S_STEP_ADV;
        end
      end
      S_STEP_ADV: begin
        op_o    = mep_pkg::OP_STEP_ADV;
        state_d = (status_i.arc_last && !status_i.pass_last) ? S_ARC_MUL : S_IDLE;
      end
      S_ARC_MUL: begin
        op_o    = mep_pkg::OP_ARC_MUL;
        state_d = S_NEXT_INIT;
      end
      S_NEXT_INIT: begin
        op_o    = mep_pkg::OP_ARC_INIT;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State register and registered ready.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      in_ready_q <= 1'b1;
    end else begin
      state_q    <= state_d;
      in_ready_q <= (state_d == S_IDLE);
    end
  end

  assign in_ready_o = in_ready_q;

endmodule

// File: sv/midpoint_ellipse_pixel_generator.sv
// ============================================================================
// midpoint_ellipse_pixel_generator: outline pixels of an axis-aligned ellipse
// Each input beat yields the next pixel of the eight-arc midpoint walk around
// the configured center, with the configured radii and color.
// ============================================================================
//
//  Channel  Port   Dir  Payload                                          Beat
//  -------  -----  ---  -----------------------------------------------  ---------------
//  tick     in_i   in   restart                                          one per pixel
//  pixel    out_o  out  pixel_x, pixel_y, color_out, arc_number,         one per tick
//                       arc_done, pass_done
//  config   cfg_i  in   index, data (register write)                     ready always high
//
//  A tick is accepted, then runs the squares, the pixel output and the step advance
//  before the next ready; the last pixel of arcs 0 to 6 also loads the next arc's
//  start values. A tick that starts a pass adds the exact arc end search of both ends,
//  which tests one bit at a time (square, multiply, compare) on the shared multiplier.
//  The result sits in an output register; a stalled output holds the walk
//  only once the next pixel is ready to be loaded.
//  After reset no pass is running and the first tick starts one.
//
module midpoint_ellipse_pixel_generator #(
  parameter int RADIUS_BITS = mep_pkg::RADIUS_BITS_DEF,
  parameter int COORD_BITS  = mep_pkg::COORD_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  mep_in_if.sink     in_i,
  mep_out_if.source  out_o,
  mep_cfg_if.sink    cfg_i
);

  logic [COORD_BITS-1:0]             center_x_q, center_y_q;
  logic [RADIUS_BITS-1:0]            radius_x_q, radius_y_q;
  logic [mep_pkg::COLOR_BITS-1:0]    pixel_color_q;
  mep_pkg::dp_op_e                   op;
  mep_pkg::dp_status_t               status;

  // Configuration registers; writes to unknown indexes are dropped.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q    <= '0;
      center_y_q    <= '0;
      radius_x_q    <= {{(RADIUS_BITS - 1){1'b0}}, 1'b1};
      radius_y_q    <= {{(RADIUS_BITS - 1){1'b0}}, 1'b1};
      pixel_color_q <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        mep_pkg::REG_CENTER_X:    center_x_q    <= cfg_i.data[COORD_BITS-1:0];
        mep_pkg::REG_CENTER_Y:    center_y_q    <= cfg_i.data[COORD_BITS-1:0];
        mep_pkg::REG_RADIUS_X:    radius_x_q    <= cfg_i.data[RADIUS_BITS-1:0];
        mep_pkg::REG_RADIUS_Y:    radius_y_q    <= cfg_i.data[RADIUS_BITS-1:0];
        mep_pkg::REG_PIXEL_COLOR: pixel_color_q <= cfg_i.data[mep_pkg::COLOR_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // Sequencer.
  mep_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .op_o       (op)
  );

  // Datapath.
  mep_dp #(
    .RADIUS_BITS (RADIUS_BITS),
    .COORD_BITS  (COORD_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .op_i          (op),
    .status_o      (status),
    .restart_i     (in_i.restart),
    .center_x_i    (center_x_q),
    .center_y_i    (center_y_q),
    .radius_x_i    (radius_x_q),
    .radius_y_i    (radius_y_q),
    .pixel_color_i (pixel_color_q),
    .out_valid_o   (out_o.valid),
    .out_ready_i   (out_o.ready),
    .pixel_x_o     (out_o.pixel_x),
    .pixel_y_o     (out_o.pixel_y),
    .color_out_o   (out_o.color_out),
    .arc_number_o  (out_o.arc_number),
    .arc_done_o    (out_o.arc_done),
    .pass_done_o   (out_o.pass_done)
  );

endmodule

// File: test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the midpoint ellipse pixel generator
// Drives tick beats, some with restart, through a range of center, radius and
// color settings. Every accepted tick is run through an in-bench model of the
// eight-arc midpoint walk, and each pixel beat is compared field by field with
// the oldest predicted pixel. Both channels idle and stall in random bursts.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int          ITEMS        = 2000;
  localparam int          SETTLE_CYCLES = 16;
  localparam int          CYCLE_LIMIT  = 1_000_000;
  localparam int          RB           = mep_pkg::RADIUS_BITS_DEF;
  localparam int          CB           = mep_pkg::COORD_BITS_DEF;
  localparam int          OCB          = mep_pkg::OUT_COORD_BITS;
  localparam int          COLB         = mep_pkg::COLOR_BITS;
  localparam int          AB           = mep_pkg::ARC_BITS;
  localparam int          IDXB         = mep_pkg::CFG_IDX_BITS;
  localparam int          DATB         = mep_pkg::CFG_DATA_BITS;
  localparam int          NUM_REGS     = 5;
  localparam int          MAX_REG_IDX  = (1 << IDXB) - 1;
  // One bit per arc: fast arcs, arcs with negated x, arcs with negated y.
  localparam logic [7:0]  FAST_ARCS    = 8'b1100_1100;
  localparam logic [7:0]  X_NEG_ARCS   = 8'b1110_0001;
  localparam logic [7:0]  Y_NEG_ARCS   = 8'b0111_1000;

  typedef struct packed {
    logic [OCB-1:0]  x;
    logic [OCB-1:0]  y;
    logic [COLB-1:0] color;
    logic [AB-1:0]   arc;
    logic            arc_done;
    logic            pass_done;
  } pixel_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  mep_in_if  tick_if ();
  mep_out_if pix_if ();
  mep_cfg_if cfg_if ();

  midpoint_ellipse_pixel_generator DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (tick_if),
    .out_o (pix_if),
    .cfg_i (cfg_if)
  );

  // Clock.
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Register copy held by the model.
  logic [CB-1:0]   ctr_x, ctr_y;
  logic [RB-1:0]   rad_x, rad_y;
  logic [COLB-1:0] color_reg;

  // Walk state of the model.
  logic [AB-1:0] cur_arc;
  longint        pos_x, pos_y, dec_f, inc_m, inc_n;
  int unsigned   arc_steps, slow_end, fast_end;
  bit            pass_running;

  bit     tick_queue[$];
  pixel_t pending_pixels[$];
  int     mismatches = 0;
  int     gap_rate = 0, stall_rate = 0;
  int     gap_left = 0, stall_left = 0;
  bit     quiet = 1'b0;
  int     cycles = 0;

  // Integer square root, rounded down.
  function automatic longint unsigned isqrt(input longint unsigned t);
    longint unsigned lo, hi, mid;
    lo = 0;
    hi = 64'hFFFF_FFFF;
    while (lo < hi) begin
      mid = lo + (hi - lo + 1) / 2;
      if (mid * mid <= t) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  // Step count of an arc: e^2 / sqrt(a^2 + b^2) rounded half up, exactly.
  function automatic int unsigned end_count(input longint unsigned e,
                                            input longint unsigned a,
                                            input longint unsigned b);
    longint unsigned den;
    den = a * a + b * b;
    if (den == 0) return 0;
    return int'((isqrt((4 * e * e * e * e) / den) + 1) / 2);
  endfunction

  // Start values of the arc in cur_arc.
  function automatic void load_arc_start();
    longint a, b, a2, b2;
    a  = longint'(rad_x);
    b  = longint'(rad_y);
    a2 = a * a;
    b2 = b * b;
    arc_steps = 0;
    if (FAST_ARCS[cur_arc]) begin
      dec_f = b2 / 4 + a2 - b2 * a;
      pos_x = a;
      pos_y = 0;
      inc_m = 3 * a2;
      inc_n = inc_m + b2 * (2 - 2 * a);
    end else begin
      dec_f = a2 / 4 + b2 - a2 * b;
      pos_x = 0;
      pos_y = b;
      inc_m = 3 * b2;
      inc_n = inc_m + a2 * (2 - 2 * b);
    end
  endfunction

  // Advance the walk by one tick and return the pixel it emits.
  function automatic pixel_t walk_step(input bit restart);
    longint        two_a2, two_b2, px_val, py_val;
    logic [AB-1:0] arc;
    int unsigned   arc_end;
    bit            fast, is_last;
    pixel_t        px;
    two_a2 = 2 * longint'(rad_x) * longint'(rad_x);
    two_b2 = 2 * longint'(rad_y) * longint'(rad_y);
    if (restart || !pass_running) begin
      pass_running = 1'b1;
      cur_arc      = '0;
      slow_end     = end_count(rad_x, rad_x, rad_y);
      fast_end     = end_count(rad_y, rad_x, rad_y);
      load_arc_start();
    end
    arc     = cur_arc;
    fast    = FAST_ARCS[arc];
    arc_end = fast ? fast_end : slow_end;

    // Fast arcs move x on decision >= 0, slow arcs move y on decision > 0.
    if (fast) begin
      if (dec_f >= 0) begin
        pos_x--;
        inc_n += two_b2;
      end
      inc_m += two_a2;
      inc_n += two_a2;
    end else begin
      if (dec_f > 0) begin
        pos_y--;
        inc_n += two_a2;
      end
      inc_m += two_b2;
      inc_n += two_b2;
    end

    px_val   = longint'(ctr_x) + (X_NEG_ARCS[arc] ? -pos_x : pos_x);
    py_val   = longint'(ctr_y) + (Y_NEG_ARCS[arc] ? -pos_y : pos_y);
    px.x     = px_val[OCB-1:0];
    px.y     = py_val[OCB-1:0];
    px.color = color_reg;
    px.arc   = arc;

    dec_f += (dec_f < 0) ? inc_m : inc_n;
    if (fast) pos_y++;
    else pos_x++;

    is_last      = (arc_steps >= arc_end);
    px.arc_done  = is_last;
    px.pass_done = is_last && (arc == mep_pkg::LAST_ARC);

    if (is_last) begin
      if (arc == mep_pkg::LAST_ARC) begin
        pass_running = 1'b0;
        cur_arc      = '0;
      end else begin
        cur_arc = arc + 1'b1;
        load_arc_start();
      end
    end else begin
      arc_steps++;
    end
    return px;
  endfunction

  // Register write as seen by the model; unknown indexes are dropped.
  function automatic void apply_reg(input logic [IDXB-1:0] idx,
                                    input logic [DATB-1:0] val);
    case (idx)
      mep_pkg::REG_CENTER_X:    ctr_x = val[CB-1:0];
      mep_pkg::REG_CENTER_Y:    ctr_y = val[CB-1:0];
      mep_pkg::REG_RADIUS_X:    rad_x = val[RB-1:0];
      mep_pkg::REG_RADIUS_Y:    rad_y = val[RB-1:0];
      mep_pkg::REG_PIXEL_COLOR: color_reg = val[COLB-1:0];
      default: ;
    endcase
  endfunction

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Tick driver: holds a beat until accepted, predicts on acceptance.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (tick_if.valid && tick_if.ready) begin
        pending_pixels.push_back(walk_step(tick_if.restart));
      end
      if (!tick_if.valid || tick_if.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          tick_if.valid <= 1'b0;
        end else if (tick_queue.size() == 0) begin
          tick_if.valid <= 1'b0;
        end else if (!quiet && gap_rate != 0 && $urandom_range(gap_rate - 1, 0) == 0) begin
          gap_left = $urandom_range(13, 0);
          tick_if.valid <= 1'b0;
        end else begin
          tick_if.valid   <= 1'b1;
          tick_if.restart <= tick_queue.pop_front();
        end
      end
    end
  end

  // Pixel monitor: checks each accepted beat and stalls at random.
  always @(posedge clk_i) begin
    pixel_t want;
    if (rst_ni) begin
      if (pix_if.valid && pix_if.ready) begin
        if (pending_pixels.size() == 0) begin
          $error("pixel beat with no tick outstanding: x %0d, y %0d",
                 pix_if.pixel_x, pix_if.pixel_y);
          mismatches++;
        end else begin
          want = pending_pixels.pop_front();
          check_field("pixel_x", $signed(want.x), pix_if.pixel_x);
          check_field("pixel_y", $signed(want.y), pix_if.pixel_y);
          check_field("color_out", want.color, pix_if.color_out);
          check_field("arc_number", want.arc, pix_if.arc_number);
          check_field("arc_done", want.arc_done, pix_if.arc_done);
          check_field("pass_done", want.pass_done, pix_if.pass_done);
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        pix_if.ready <= 1'b0;
      end else if (!quiet && stall_rate != 0 && $urandom_range(stall_rate - 1, 0) == 0) begin
        stall_left = $urandom_range(13, 0);
        pix_if.ready <= 1'b0;
      end else begin
        pix_if.ready <= 1'b1;
      end
    end
  end

  // Run limit.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Wait until every tick is accepted and every pixel checked, then let the
  // block finish its step advance before anything else happens. The check is
  // made on the falling edge, once the rising edge updates have settled.
  task automatic wait_idle();
    do @(negedge clk_i);
    while (tick_queue.size() != 0 || tick_if.valid || pending_pixels.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // One register write beat; valid stays high for a following write.
  task automatic cfg_write(input logic [IDXB-1:0] idx,
                           input logic [DATB-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    apply_reg(idx, val);
  endtask

  // Write all five registers, with an optional write to an unused index.
  task automatic write_settings(input logic [CB-1:0] cx, input logic [CB-1:0] cy,
                                input logic [RB-1:0] rx, input logic [RB-1:0] ry,
                                input logic [COLB-1:0] col, input bit stray);
    wait_idle();
    if (stray) cfg_write(IDXB'($urandom_range(MAX_REG_IDX, NUM_REGS)), DATB'($urandom()));
    cfg_write(mep_pkg::REG_CENTER_X, DATB'(cx));
    cfg_write(mep_pkg::REG_CENTER_Y, DATB'(cy));
    cfg_write(mep_pkg::REG_RADIUS_X, DATB'(rx));
    cfg_write(mep_pkg::REG_RADIUS_Y, DATB'(ry));
    cfg_write(mep_pkg::REG_PIXEL_COLOR, DATB'(col));
    cfg_if.valid <= 1'b0;
  endtask

  function automatic logic [RB-1:0] wide_radius();
    case ($urandom_range(2, 0))
      0:       return {RB{1'b1}};
      1:       return RB'(1);
      default: return RB'($urandom_range(1023, 256));
    endcase
  endfunction

  function automatic logic [CB-1:0] pick_center();
    if ($urandom_range(3, 0) == 0) return $urandom_range(1, 0) ? {CB{1'b1}} : '0;
    return CB'($urandom_range(4095, 0));
  endfunction

  // Stimulus.
  initial begin
    int            n, total;
    bit            wide, prev_wide;
    logic [RB-1:0] rx, ry;

    tick_if.valid   = 1'b0;
    tick_if.restart = 1'b0;
    pix_if.ready    = 1'b0;
    cfg_if.valid    = 1'b0;
    cfg_if.index    = '0;
    cfg_if.data     = '0;
    rst_ni          = 1'b0;

    ctr_x        = '0;
    ctr_y        = '0;
    rad_x        = RB'(1);
    rad_y        = RB'(1);
    color_reg    = '0;
    cur_arc      = '0;
    pos_x        = 0;
    pos_y        = 0;
    arc_steps    = 0;
    dec_f        = 0;
    inc_m        = 0;
    inc_n        = 0;
    slow_end     = 0;
    fast_end     = 0;
    pass_running = 1'b0;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings, no restart: the first tick starts a pass, and a full
    // pass of unit radii wraps into the next one.
    repeat (17) tick_queue.push_back(1'b0);

    // Largest center and radii: coordinates stay within the output range.
    write_settings({CB{1'b1}}, {CB{1'b1}}, {RB{1'b1}}, {RB{1'b1}}, {COLB{1'b1}}, 1'b1);
    tick_queue.push_back(1'b1);
    tick_queue.push_back(1'b0);

    // Both radii zero: every arc is a single pixel.
    write_settings('0, '0, '0, '0, '0, 1'b0);
    tick_queue.push_back(1'b1);
    tick_queue.push_back(1'b0);
    tick_queue.push_back(1'b0);

    // One radius zero at the origin: negative coordinates.
    write_settings('0, '0, RB'(2), '0, COLB'($urandom()), 1'b1);
    tick_queue.push_back(1'b1);
    tick_queue.push_back(1'b0);
    tick_queue.push_back(1'b0);

    total     = 25;
    prev_wide = 1'b1;

    // Random phases: mostly small ellipses walked through whole passes, now
    // and then a large one that only gets its pass start exercised.
    while (total < ITEMS) begin
      wide = ($urandom_range(7, 0) == 0);
      if (wide) begin
        rx = wide_radius();
        ry = wide_radius();
        n  = $urandom_range(40, 20);
      end else begin
        rx = ($urandom_range(15, 0) == 0) ? '0 : RB'($urandom_range(40, 1));
        ry = ($urandom_range(15, 0) == 0) ? '0 : RB'($urandom_range(40, 1));
        n  = $urandom_range(150, 40);
      end
      write_settings(pick_center(), pick_center(), rx, ry, COLB'($urandom()),
                     $urandom_range(3, 0) == 0);
      case ($urandom_range(2, 0))
        0:       gap_rate = 0;
        1:       gap_rate = 16;
        default: gap_rate = 4;
      endcase
      case ($urandom_range(2, 0))
        0:       stall_rate = 0;
        1:       stall_rate = 16;
        default: stall_rate = 4;
      endcase
      if (total >= ITEMS - 250) quiet = 1'b1;
      // A small phase may carry on the running pass with the new settings.
      tick_queue.push_back(wide || prev_wide || $urandom_range(1, 0) == 1);
      for (int i = 1; i < n; i++) tick_queue.push_back($urandom_range(149, 0) == 0);
      total += n;
      prev_wide = wide;
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: files.f
sv/mep_pkg.sv
sv/mep_if.sv
sv/mep_dp.sv
sv/mep_ctrl.sv
sv/midpoint_ellipse_pixel_generator.sv
test/tb_top.sv
